### sv/average_directional_index_assert.svh
// Assertion macros for the average directional index block.
// Included by the top level; depends on nothing else.
`ifndef AVERAGE_DIRECTIONAL_INDEX_ASSERT_SVH
`define AVERAGE_DIRECTIONAL_INDEX_ASSERT_SVH

// Check that an antecedent implies a consequent in the same cycle.
`define ADX_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check that an antecedent implies a consequent in the next cycle.
`define ADX_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### sv/adx_pkg.sv
// Shared types and constants for the average directional index block.
// No dependencies.
package adx_pkg;

  localparam int unsigned PriceBits = 24;
  localparam int unsigned FracBits  = 8;
  localparam int unsigned SumBits   = 40;
  localparam int unsigned OutBits   = 15;
  localparam int unsigned AccBits   = 24;
  localparam int unsigned IdxBits   = 9;
  localparam int unsigned QuoBits   = 56;
  localparam logic [SumBits-1:0] SumMax    = '1;
  localparam logic [OutBits-1:0] FullScale = OutBits'(100 << FracBits);
  localparam logic [7:0] PeriodReset = 8'd14;
  localparam logic [0:0] RegPeriod   = 1'b0;

  typedef struct packed {
    logic                 start;
    logic [PriceBits-1:0] high;
    logic [PriceBits-1:0] low;
    logic [PriceBits-1:0] close;
  } bar_t;

  typedef struct packed {
    logic [OutBits-1:0] plus_di;
    logic [OutBits-1:0] minus_di;
    logic [OutBits-1:0] dir_index;
    logic [OutBits-1:0] avg_dir_index;
    logic               di_valid;
    logic               adx_valid;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MOVE, ST_DIVR, ST_DIVP, ST_DIVM, ST_SMOOTH, ST_DIP, ST_DIM,
    ST_DXS, ST_DX, ST_ADXM, ST_ADX, ST_OUT
  } eng_state_e;

endpackage

### sv/adx_divider.sv
// Restoring divider, one quotient bit per cycle.
// Depends on adx_pkg.
module adx_divider (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [adx_pkg::QuoBits-1:0]      num_i,
  input  logic [adx_pkg::SumBits-1:0]      den_i,
  output logic                             done_o,
  output logic [adx_pkg::QuoBits-1:0]      quo_o
);
  localparam int unsigned CntBits = $clog2(adx_pkg::QuoBits + 1);

  logic [adx_pkg::QuoBits-1:0] quo_q, quo_d;
  logic [adx_pkg::SumBits:0]   rem_q, rem_d, trial;
  logic [adx_pkg::SumBits-1:0] den_q, den_d;
  logic [CntBits-1:0]          cnt_q, cnt_d;
  logic                        busy_q, busy_d, done_q, done_d;

  // Shift one numerator bit into the remainder and try a subtract
  always_comb begin
    quo_d = quo_q; rem_d = rem_q; den_d = den_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    trial = {rem_q[adx_pkg::SumBits-1:0], quo_q[adx_pkg::QuoBits-1]};
    if (start_i) begin
      quo_d = num_i; rem_d = '0; den_d = den_i; busy_d = 1'b1;
      cnt_d = CntBits'(adx_pkg::QuoBits);
    end else if (busy_q) begin
      quo_d = {quo_q[adx_pkg::QuoBits-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d[0] = 1'b1;
      end else begin
        rem_d = trial;
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntBits'(1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d; rem_q <= rem_d; den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = (den_q == '0) ? '0 : quo_q;
endmodule

### sv/adx_front.sv
// Front end: a two-entry bar queue.
// Depends on adx_pkg.
module adx_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  adx_pkg::bar_t      in_bar_i,
  output logic               q_valid_o,
  input  logic               q_pop_i,
  output adx_pkg::bar_t      q_bar_o
);
  adx_pkg::bar_t mem_q [2];
  logic          wp_q, rp_q;
  logic [1:0]    cnt_q;
  logic          push;

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_bar_o    = mem_q[rp_q];

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (q_pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= in_bar_i;
  end
endmodule

### sv/adx_engine.sv
// Back end: sequencer computing Wilder sums, DI, DX and ADX for one bar.
// Depends on adx_pkg and adx_divider.
module adx_engine (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [7:0]          period_i,
  input  logic                q_valid_i,
  output logic                q_pop_o,
  input  adx_pkg::bar_t       q_bar_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output adx_pkg::res_t       res_o
);
  localparam int unsigned SB = adx_pkg::SumBits;
  localparam int unsigned PB = adx_pkg::PriceBits;
  localparam int unsigned QB = adx_pkg::QuoBits;
  localparam int unsigned OB = adx_pkg::OutBits;
  localparam int unsigned AB = adx_pkg::AccBits;

  adx_pkg::eng_state_e state_q, state_d;
  adx_pkg::bar_t       bar_q;
  logic [PB-1:0] ph_q, pl_q, pc_q;
  logic [adx_pkg::IdxBits-1:0] idx_q;
  logic [SB-1:0] rs_q, ps_q, ms_q;
  logic [AB-1:0] acc_q;
  logic [PB-1:0] tr_q, pdm_q, mdm_q;
  logic [SB-1:0] qr_q, qp_q, qm_q;
  logic [OB-1:0] pdi_q, mdi_q, dx_q;
  logic [QB-1:0] prod_q;
  adx_pkg::res_t res_q;
  logic          res_v_q;

  logic [8:0]    n, n2, cur;
  logic          div_start, div_done;
  logic [QB-1:0] div_num, div_quo;
  logic [SB-1:0] div_den;
  logic [PB-1:0] tr, t2, t3, up, dn;
  logic [SB:0]   rsum, psum, msum;
  logic [OB-1:0] sat_q;
  logic [AB:0]   acc_add;

  assign n   = (period_i < 8'd2) ? 9'd2 : {1'b0, period_i};
  assign n2  = {n[7:0], 1'b0};
  assign cur = (idx_q > n2) ? n2 : idx_q;

  adx_divider u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quo_o(div_quo)
  );

  // Move terms from the current and previous bar
  always_comb begin
    tr = (bar_q.high >= bar_q.low) ? bar_q.high - bar_q.low : '0;
    t2 = (bar_q.high >= pc_q) ? bar_q.high - pc_q : pc_q - bar_q.high;
    t3 = (bar_q.low >= pc_q) ? bar_q.low - pc_q : pc_q - bar_q.low;
    if (t2 > tr) tr = t2;
    if (t3 > tr) tr = t3;
    up = (bar_q.high > ph_q) ? bar_q.high - ph_q : '0;
    dn = (pl_q > bar_q.low) ? pl_q - bar_q.low : '0;
  end

  // Saturate a quotient to full scale
  assign sat_q   = (div_quo > QB'(adx_pkg::FullScale)) ? adx_pkg::FullScale
                                                         : div_quo[OB-1:0];
  assign acc_add = {1'b0, acc_q} + (AB+1)'(dx_q);

  // Smoothed or seeded sums
  always_comb begin
    if (cur <= n) begin
      rsum = {1'b0, rs_q} + (SB+1)'(tr_q);
      psum = {1'b0, ps_q} + (SB+1)'(pdm_q);
      msum = {1'b0, ms_q} + (SB+1)'(mdm_q);
    end else begin
      rsum = {1'b0, rs_q - qr_q} + (SB+1)'(tr_q);
      psum = {1'b0, ps_q - qp_q} + (SB+1)'(pdm_q);
      msum = {1'b0, ms_q - qm_q} + (SB+1)'(mdm_q);
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      adx_pkg::ST_IDLE:   if (q_valid_i && !res_v_q) state_d = adx_pkg::ST_MOVE;
      adx_pkg::ST_MOVE:   state_d = (cur == '0) ? adx_pkg::ST_OUT
                                  : (cur <= n) ? adx_pkg::ST_SMOOTH : adx_pkg::ST_DIVR;
      adx_pkg::ST_DIVR:   if (div_done) state_d = adx_pkg::ST_DIVP;
      adx_pkg::ST_DIVP:   if (div_done) state_d = adx_pkg::ST_DIVM;
      adx_pkg::ST_DIVM:   if (div_done) state_d = adx_pkg::ST_SMOOTH;
      adx_pkg::ST_SMOOTH: state_d = (cur >= n) ? adx_pkg::ST_DIP : adx_pkg::ST_OUT;
      adx_pkg::ST_DIP:    if (div_done) state_d = adx_pkg::ST_DIM;
      adx_pkg::ST_DIM:    if (div_done) state_d = adx_pkg::ST_DXS;
      adx_pkg::ST_DXS:    state_d = adx_pkg::ST_DX;
      adx_pkg::ST_DX:     if (div_done) state_d = (cur < n2 - 9'd1) ? adx_pkg::ST_OUT
                                                                    : adx_pkg::ST_ADXM;
      adx_pkg::ST_ADXM:   state_d = adx_pkg::ST_ADX;
      adx_pkg::ST_ADX:    if (div_done) state_d = adx_pkg::ST_OUT;
      adx_pkg::ST_OUT:    state_d = adx_pkg::ST_IDLE;
      default:            state_d = adx_pkg::ST_IDLE;
    endcase
  end

  // Divider operands and start pulses
  always_comb begin
    div_start = 1'b0; div_num = '0; div_den = '0;
    case (state_q)
      adx_pkg::ST_MOVE: begin
        div_start = (cur > n); div_num = QB'(rs_q); div_den = SB'(n);
      end
      adx_pkg::ST_DIVR: begin
        div_start = div_done; div_num = QB'(ps_q); div_den = SB'(n);
      end
      adx_pkg::ST_DIVP: begin
        div_start = div_done; div_num = QB'(ms_q); div_den = SB'(n);
      end
      adx_pkg::ST_SMOOTH: begin
        div_start = (cur >= n);
        div_num = (psum[SB] ? QB'(adx_pkg::SumMax) : QB'(psum[SB-1:0]))
                  * QB'(adx_pkg::FullScale);
        div_den = rsum[SB] ? adx_pkg::SumMax : rsum[SB-1:0];
      end
      adx_pkg::ST_DIP: begin
        div_start = div_done; div_num = QB'(ms_q) * QB'(adx_pkg::FullScale);
        div_den = rs_q;
      end
      adx_pkg::ST_DXS: begin
        div_start = 1'b1; div_num = prod_q;
        div_den = SB'(pdi_q) + SB'(mdi_q);
      end
      adx_pkg::ST_ADXM: begin
        div_start = 1'b1;
        // Mean of the seed DX sum, or the running ADX update
        if (cur == n2 - 9'd1) div_num = QB'(acc_add[AB-1:0]);
        else div_num = QB'(acc_q) * QB'(n - 9'd1) + QB'(dx_q);
        div_den = SB'(n);
      end
      default: ;
    endcase
  end

  assign q_pop_o     = (state_q == adx_pkg::ST_IDLE) && q_valid_i && !res_v_q;
  assign res_valid_o = res_v_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= adx_pkg::ST_IDLE;
      res_v_q <= 1'b0;
      idx_q <= '0; rs_q <= '0; ps_q <= '0; ms_q <= '0; acc_q <= '0;
      ph_q <= '0; pl_q <= '0; pc_q <= '0;
    end else begin
      state_q <= state_d;
      if (res_v_q && res_ready_i) res_v_q <= 1'b0;
      case (state_q)
        adx_pkg::ST_IDLE: if (q_pop_o && q_bar_i.start) begin
          idx_q <= '0; rs_q <= '0; ps_q <= '0; ms_q <= '0; acc_q <= '0;
          ph_q <= '0; pl_q <= '0; pc_q <= '0;
        end
        adx_pkg::ST_SMOOTH: begin
          rs_q <= rsum[SB] ? adx_pkg::SumMax : rsum[SB-1:0];
          ps_q <= psum[SB] ? adx_pkg::SumMax : psum[SB-1:0];
          ms_q <= msum[SB] ? adx_pkg::SumMax : msum[SB-1:0];
        end
        adx_pkg::ST_DX: if (div_done) begin
          if (cur < n2 - 9'd1) acc_q <= acc_q + AB'(sat_q);
        end
        adx_pkg::ST_ADX: if (div_done) acc_q <= AB'(sat_q);
        adx_pkg::ST_OUT: begin
          res_v_q <= 1'b1;
          ph_q <= bar_q.high; pl_q <= bar_q.low; pc_q <= bar_q.close;
          idx_q <= (cur + 9'd1 > n2) ? n2 : cur + 9'd1;
        end
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      adx_pkg::ST_IDLE: if (q_pop_o) bar_q <= q_bar_i;
      adx_pkg::ST_MOVE: begin
        tr_q  <= tr;
        pdm_q <= (up != '0 && up > dn) ? up : '0;
        mdm_q <= (dn != '0 && dn > up) ? dn : '0;
        res_q <= '0;
      end
      adx_pkg::ST_DIVR: if (div_done) qr_q <= div_quo[SB-1:0];
      adx_pkg::ST_DIVP: if (div_done) qp_q <= div_quo[SB-1:0];
      adx_pkg::ST_DIVM: if (div_done) qm_q <= div_quo[SB-1:0];
      adx_pkg::ST_DIP:  if (div_done) pdi_q <= sat_q;
      adx_pkg::ST_DIM:  if (div_done) begin
        mdi_q <= sat_q;
        prod_q <= QB'((pdi_q >= sat_q) ? pdi_q - sat_q : sat_q - pdi_q)
                  * QB'(adx_pkg::FullScale);
      end
      adx_pkg::ST_DX: if (div_done) begin
        dx_q <= sat_q;
        res_q.plus_di <= pdi_q; res_q.minus_di <= mdi_q;
        res_q.dir_index <= sat_q; res_q.di_valid <= 1'b1;
      end
      adx_pkg::ST_ADXM: res_q.adx_valid <= 1'b1;
      adx_pkg::ST_ADX: if (div_done) res_q.avg_dir_index <= sat_q;
      default: ;
    endcase
  end
endmodule

### sv/average_directional_index.sv
// Top level of the average directional index block: APB register, front queue, engine.
// Depends on adx_pkg, adx_front, adx_engine and the assertion header.
//
//  channel  | direction | handshake
//  s_axis   | in        | s_axis_tvalid/tready, tuser = start_series
//  m_axis   | out       | m_axis_tvalid/tready
//  apb      | in        | psel/penable/pwrite, period_length at 0x0
//
// The work per bar is set by the runs of the shared divider: three sum divisions by
// N, two DI ratios, DX and ADX. Bar zero and the early seeding bars skip the divider,
// and the engine takes no new bar until the result transfer is done. Reset clears
// all running state. A held result stalls the engine; the two-entry queue keeps
// taking bars until it is full.
`include "average_directional_index_assert.svh"
module average_directional_index (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // bar_high, bar_low, bar_close
  input  logic        s_axis_tuser,   // start_series
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // plus_di, minus_di, dir_index, avg_dir_index,
                                      // di_valid, adx_valid, zero fill
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [7:0]     period_q;
  adx_pkg::bar_t  in_bar, q_bar;
  adx_pkg::res_t  res;
  logic           q_valid, q_pop;

  assign pready = 1'b1;
  assign prdata = (paddr[1] == adx_pkg::RegPeriod) ? {24'd0, period_q} : '0;

  // Hold the period register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) period_q <= adx_pkg::PeriodReset;
    else if (psel && penable && pwrite && paddr[1] == adx_pkg::RegPeriod)
      period_q <= pwdata[7:0];
  end

  assign in_bar = '{start: s_axis_tuser, high: s_axis_tdata[23:0],
                    low: s_axis_tdata[47:24], close: s_axis_tdata[71:48]};

  adx_front u_front (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_bar_i(in_bar), .q_valid_o(q_valid), .q_pop_i(q_pop), .q_bar_o(q_bar)
  );

  adx_engine u_engine (
    .clk_i, .rst_ni, .period_i(period_q), .q_valid_i(q_valid), .q_pop_o(q_pop),
    .q_bar_i(q_bar), .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready),
    .res_o(res)
  );

  assign m_axis_tdata = {2'b00, res.adx_valid, res.di_valid, res.avg_dir_index,
                         res.dir_index, res.minus_di, res.plus_di};

  `ADX_ASSERT_SAME(a_adx_needs_di, clk_i, rst_ni, m_axis_tvalid && res.adx_valid, res.di_valid)
  `ADX_ASSERT_NEXT(a_out_holds, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `ADX_ASSERT_SAME(a_pop_only_valid, clk_i, rst_ni, q_pop, q_valid)
endmodule
